// File: hw/rtl/evag_pkg.sv
// Shared constants, types and register codes for the energy voice activity gate.
package evag_pkg;

   // Frame and field geometry
   localparam int FRAME_SAMPLES = 320;
   localparam int SAMPLE_W      = 16;
   localparam int TIME_W        = 32;
   localparam int CFG_W         = 16;
   localparam int LEVEL_W       = 16;
   localparam int SUM_W         = 24;
   localparam int IDX_W         = 9;
   localparam int ABS_W         = SAMPLE_W + 1;

   // Frame length as a vector; FS_W holds the largest legal frame (512)
   localparam int FS_W = 10;
   localparam logic [FS_W-1:0] FRAME_LEN  = FS_W'(FRAME_SAMPLES);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(FRAME_SAMPLES - 1);

   // Reciprocal divide: q0 = (sum * RECIP) >> RECIP_SHIFT is the quotient or one below
   localparam int RECIP_SHIFT = SUM_W;
   localparam int RECIP_W     = SUM_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'((64'd1 << RECIP_SHIFT) / FRAME_SAMPLES);
   localparam int PROD_W = SUM_W + RECIP_W;
   localparam int QF_W   = SUM_W + FS_W;
   localparam int REM_W  = FS_W + 1;

   // Frame queue
   localparam int QDEPTH = 4;
   localparam int QPTR_W = 2;
   localparam int QCNT_W = 3;

   // Configuration port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_VOICE_THRESHOLD    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_MIN_VOICE_MS       = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_SILENCE_TIMEOUT_MS = 2'd2;

   localparam logic [CFG_W-1:0] RST_VOICE_THRESHOLD    = 16'd1000;
   localparam logic [CFG_W-1:0] RST_MIN_VOICE_MS       = 16'd200;
   localparam logic [CFG_W-1:0] RST_SILENCE_TIMEOUT_MS = 16'd1500;

   // One finished frame handed from front to back
   typedef struct packed {
      logic [SUM_W-1:0]  sum;
      logic [TIME_W-1:0] now_ms;
   } frame_type;

   // Configuration registers as seen by the back end
   typedef struct packed {
      logic [CFG_W-1:0] voice_threshold;
      logic [CFG_W-1:0] min_voice_ms;
      logic [CFG_W-1:0] silence_timeout_ms;
   } cfg_type;

endpackage

// File: hw/rtl/evag_req_if.sv
// Sample input channel: valid/ready handshake carrying one audio word.
interface evag_req_if;
   import evag_pkg::*;

   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;
   logic [TIME_W-1:0]          now_ms;

   modport source (output valid, output sample, output now_ms, input ready);
   modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

// File: hw/rtl/evag_rsp_if.sv
// Frame result channel: valid/ready handshake carrying one gate status word.
interface evag_rsp_if;
   import evag_pkg::*;

   logic               valid;
   logic               ready;
   logic               sending;
   logic               voice;
   logic [LEVEL_W-1:0] avg_level;
   logic               started;
   logic               stopped;

   modport source (output valid, output sending, output voice, output avg_level,
                   output started, output stopped, input ready);
   modport sink   (input valid, input sending, input voice, input avg_level,
                   input started, input stopped, output ready);
endinterface

// File: hw/rtl/evag_front.sv
// Front end: accepts samples, accumulates absolute level, emits one word per frame.
module evag_front (
   input  logic                 clock,
   input  logic                 reset,
   evag_req_if.sink             req,
   input  logic                 q_full,
   output logic                 q_push,
   output evag_pkg::frame_type  q_data
);
   import evag_pkg::*;

   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [ABS_W-1:0] abs_val;
   logic [SUM_W:0]   add_val;
   logic [SUM_W-1:0] sat_sum;
   logic             accept;
   logic             last;

   assign req.ready = !q_full;
   assign accept    = req.valid && req.ready;
   assign last      = (idx_ff == LAST_IDX);

   // Absolute value, saturating accumulate
   always_comb begin
      abs_val = req.sample[SAMPLE_W-1] ? (ABS_W'(0) - {req.sample[SAMPLE_W-1], req.sample})
                                       : {1'b0, req.sample};
      add_val = {1'b0, sum_ff} + (SUM_W+1)'(abs_val);
      sat_sum = add_val[SUM_W] ? {SUM_W{1'b1}} : add_val[SUM_W-1:0];
   end

   // Frame counter and sum update
   always_comb begin
      sum_in = sum_ff;
      idx_in = idx_ff;
      if (accept) begin
         if (last) begin
            sum_in = '0;
            idx_in = '0;
         end else begin
            sum_in = sat_sum;
            idx_in = idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
         idx_ff <= '0;
      end else begin
         sum_ff <= sum_in;
         idx_ff <= idx_in;
      end
   end

   // Frame word goes to the queue on the last sample
   assign q_push        = accept && last;
   assign q_data.sum    = sat_sum;
   assign q_data.now_ms = req.now_ms;

endmodule

// File: hw/rtl/evag_queue.sv
// Short frame queue between front and back ends.
module evag_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  evag_pkg::frame_type  push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 empty,
   output evag_pkg::frame_type  pop_data
);
   import evag_pkg::*;

   frame_type         mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ff, wr_in;
   logic [QPTR_W-1:0] rd_ff, rd_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full     = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   // Pointer and fill count update
   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_W'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// File: hw/rtl/evag_back.sv
// Back end: divides the frame sum, classifies voice and runs the gate state.
module evag_back (
   input  logic                 clock,
   input  logic                 reset,
   input  evag_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  evag_pkg::frame_type  q_data,
   output logic                 q_pop,
   evag_rsp_if.source           rsp
);
   import evag_pkg::*;

   // Pipeline valids and stall
   logic v1_ff, v2_ff, v3_ff, out_v_ff;
   logic v1_in, v2_in, v3_in, out_v_in;
   logic adv;

   // Stage 1: reciprocal product
   logic [PROD_W-1:0] prod_ff;
   logic [SUM_W-1:0]  sum1_ff;
   logic [TIME_W-1:0] now1_ff;
   // Stage 2: estimate and back-multiply
   logic [SUM_W-1:0]  q2_ff;
   logic [QF_W-1:0]   qf2_ff;
   logic [SUM_W-1:0]  sum2_ff;
   logic [TIME_W-1:0] now2_ff;
   // Stage 3: corrected average and voice flag
   logic [LEVEL_W-1:0] avg3_ff;
   logic               voice3_ff;
   logic [TIME_W-1:0]  now3_ff;

   logic [SUM_W-1:0]  q_est;
   logic [SUM_W-1:0]  rem_full;
   logic [REM_W-1:0]  rem;
   logic [SUM_W-1:0]  avg_full;
   logic              voice_in;

   // Gate state
   logic              gate_ff, gate_in;
   logic              prev_ff, prev_in;
   logic [TIME_W-1:0] onset_ff, onset_in;
   logic [TIME_W-1:0] last_ff, last_in;
   logic [TIME_W-1:0] dt_on;
   logic [TIME_W-1:0] dt_last;
   logic              started_in;
   logic              stopped_in;

   // Whole pipeline moves when the output word is free or being taken
   assign adv   = !out_v_ff || rsp.ready;
   assign q_pop = adv && !q_empty;

   always_comb begin
      v1_in    = adv ? q_pop : v1_ff;
      v2_in    = adv ? v1_ff : v2_ff;
      v3_in    = adv ? v2_ff : v3_ff;
      out_v_in = adv ? v3_ff : out_v_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         v3_ff    <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         v1_ff    <= v1_in;
         v2_ff    <= v2_in;
         v3_ff    <= v3_in;
         out_v_ff <= out_v_in;
      end
   end

   // Division datapath
   always_comb begin
      q_est    = prod_ff[RECIP_SHIFT +: SUM_W];
      rem_full = sum2_ff - qf2_ff[SUM_W-1:0];
      rem      = rem_full[REM_W-1:0];
      avg_full = q2_ff + SUM_W'(rem >= REM_W'(FRAME_LEN));
      voice_in = avg_full > SUM_W'(cfg.voice_threshold);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod_ff   <= PROD_W'(q_data.sum) * PROD_W'(RECIP);
         sum1_ff   <= q_data.sum;
         now1_ff   <= q_data.now_ms;
         q2_ff     <= q_est;
         qf2_ff    <= QF_W'(q_est) * QF_W'(FRAME_LEN);
         sum2_ff   <= sum1_ff;
         now2_ff   <= now1_ff;
         avg3_ff   <= avg_full[LEVEL_W-1:0];
         voice3_ff <= voice_in;
         now3_ff   <= now2_ff;
      end
   end

   // Onset qualification and silence hangover
   always_comb begin
      dt_on      = prev_ff ? (now3_ff - onset_ff) : '0;
      dt_last    = now3_ff - last_ff;
      gate_in    = gate_ff;
      prev_in    = prev_ff;
      onset_in   = onset_ff;
      last_in    = last_ff;
      started_in = 1'b0;
      stopped_in = 1'b0;
      if (v3_ff && adv) begin
         prev_in = voice3_ff;
         if (voice3_ff) begin
            last_in = now3_ff;
            if (!prev_ff) begin
               onset_in = now3_ff;
            end
            if (!gate_ff && (dt_on >= TIME_W'(cfg.min_voice_ms))) begin
               gate_in    = 1'b1;
               started_in = 1'b1;
            end
         end else if (gate_ff && (dt_last >= TIME_W'(cfg.silence_timeout_ms))) begin
            gate_in    = 1'b0;
            stopped_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gate_ff  <= 1'b0;
         prev_ff  <= 1'b0;
         onset_ff <= '0;
         last_ff  <= '0;
      end else begin
         gate_ff  <= gate_in;
         prev_ff  <= prev_in;
         onset_ff <= onset_in;
         last_ff  <= last_in;
      end
   end

   // Output word register
   logic               o_sending_ff;
   logic               o_voice_ff;
   logic [LEVEL_W-1:0] o_avg_ff;
   logic               o_started_ff;
   logic               o_stopped_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         o_sending_ff <= gate_in;
         o_voice_ff   <= voice3_ff;
         o_avg_ff     <= avg3_ff;
         o_started_ff <= started_in;
         o_stopped_ff <= stopped_in;
      end
   end

   assign rsp.valid     = out_v_ff;
   assign rsp.sending   = o_sending_ff;
   assign rsp.voice     = o_voice_ff;
   assign rsp.avg_level = o_avg_ff;
   assign rsp.started   = o_started_ff;
   assign rsp.stopped   = o_stopped_ff;

endmodule

// File: hw/rtl/energy_voice_activity_gate.sv
// Energy voice activity gate: the top level with its configuration registers.
// Takes one audio sample word per clock cycle. Absolute sample values are
// summed over a frame of FRAME_SAMPLES samples; on the last sample the frame
// word (sum and timestamp) drops into a four-entry queue. The back end divides
// by the frame length with a reciprocal multiply and one correction step,
// compares against the threshold and runs the onset and hangover logic, one
// frame per cycle from queue to a registered result word. A result word that
// waits at the output stalls the back end only; samples keep flowing until
// four frames are queued. Registers (32-bit APB, zero wait states): 0x0 voice
// threshold, 0x4 minimum voice time in ms, 0x8 silence timeout in ms.
module energy_voice_activity_gate (
   input  logic                              clock,
   input  logic                              reset,
   evag_req_if.sink                          req_chan,
   evag_rsp_if.source                        rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [evag_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [evag_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [evag_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready
);
   import evag_pkg::*;

   logic [CFG_W-1:0]     thr_ff, thr_in;
   logic [CFG_W-1:0]     minv_ff, minv_in;
   logic [CFG_W-1:0]     sil_ff, sil_in;
   logic [REG_IDX_W-1:0] reg_idx;
   logic                 wr_en;
   cfg_type              cfg;

   logic      q_push;
   logic      q_pop;
   logic      q_full;
   logic      q_empty;
   frame_type q_wdata;
   frame_type q_rdata;

   // Register write decode
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[CSR_ADDR_W-1:2];

   always_comb begin
      thr_in  = thr_ff;
      minv_in = minv_ff;
      sil_in  = sil_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_VOICE_THRESHOLD:    thr_in  = pwdata[CFG_W-1:0];
            REG_MIN_VOICE_MS:       minv_in = pwdata[CFG_W-1:0];
            REG_SILENCE_TIMEOUT_MS: sil_in  = pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff  <= RST_VOICE_THRESHOLD;
         minv_ff <= RST_MIN_VOICE_MS;
         sil_ff  <= RST_SILENCE_TIMEOUT_MS;
      end else begin
         thr_ff  <= thr_in;
         minv_ff <= minv_in;
         sil_ff  <= sil_in;
      end
   end

   // Register read mux
   always_comb begin
      case (reg_idx)
         REG_VOICE_THRESHOLD:    prdata = CSR_DATA_W'(thr_ff);
         REG_MIN_VOICE_MS:       prdata = CSR_DATA_W'(minv_ff);
         REG_SILENCE_TIMEOUT_MS: prdata = CSR_DATA_W'(sil_ff);
         default:                prdata = '0;
      endcase
   end

   assign cfg.voice_threshold    = thr_ff;
   assign cfg.min_voice_ms       = minv_ff;
   assign cfg.silence_timeout_ms = sil_ff;

   evag_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req_chan),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_wdata)
   );

   evag_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .empty     (q_empty),
      .pop_data  (q_rdata)
   );

   evag_back u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_data  (q_rdata),
      .q_pop   (q_pop),
      .rsp     (rsp_chan)
   );

endmodule

// File: hw/rtl/evag_checker.sv
// Port-level checks for the voice activity gate, bound to the top level.
module evag_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_sending,
   input logic rsp_voice,
   input logic rsp_started,
   input logic rsp_stopped
);

   // Result word holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   // Nothing comes out right after reset
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word valid after reset");

   // Opening needs a voice frame and leaves the gate open
   a_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_started |-> rsp_sending && rsp_voice && !rsp_stopped)
      else $error("gate opened without voice");

   // Closing only on a silent frame and leaves the gate shut
   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stopped |-> !rsp_sending && !rsp_voice)
      else $error("gate closed on voice frame");

endmodule

bind energy_voice_activity_gate evag_checker u_evag_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_sending (rsp_chan.sending),
   .rsp_voice   (rsp_chan.voice),
   .rsp_started (rsp_chan.started),
   .rsp_stopped (rsp_chan.stopped)
);

// File: tb/testbench.sv
// Self-checking testbench for the energy voice activity gate: directed frames, then random phases.
`timescale 1ns / 100ps

module testbench;
   import evag_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES   = 3000;
   localparam logic [REG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

   typedef struct packed {
      logic               sending;
      logic               voice;
      logic [LEVEL_W-1:0] avg_level;
      logic               started;
      logic               stopped;
   } gate_word_type;

   typedef enum logic [0:0] {ROW_FRAME, ROW_WRITE} row_kind_type;
   typedef enum logic [2:0] {
      PAT_POS, PAT_NEG, PAT_ALT, PAT_RAMP, PAT_NOISE, PAT_SPREAD
   } pattern_type;

   typedef struct packed {
      row_kind_type         kind;
      logic [REG_IDX_W-1:0] csr_idx;
      logic [CFG_W-1:0]     wdata;
      pattern_type          pattern;
      logic [16:0]          mag;
      logic [TIME_W-1:0]    stamp;
      logic                 pinned;
      gate_word_type        want;
   } plan_row_type;

   bit   clock;
   logic reset;
   logic psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   evag_req_if req_chan ();
   evag_rsp_if rsp_chan ();

   energy_voice_activity_gate dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Gate predictor state
   logic [CFG_W-1:0]  cfg_model [0:REG_SILENCE_TIMEOUT_MS];
   logic [SUM_W-1:0]  acc_level;
   int                acc_count;
   logic              gate_is_open;
   logic              last_was_voice;
   logic [TIME_W-1:0] onset_stamp;
   logic [TIME_W-1:0] voice_stamp;

   gate_word_type pending_words [$];
   logic          pin_active = 1'b0;
   gate_word_type pin_word;

   int sender_idle_pct = 0;
   int sink_stall_pct  = 0;
   int hold_requests   = 0;
   int mismatches      = 0;
   int samples_sent    = 0;
   int words_checked   = 0;
   int voice_seen      = 0;
   int opens_seen      = 0;
   int closes_seen     = 0;
   int cycle_count     = 0;
   logic [TIME_W-1:0] clock_ms = '0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(string name, int want, int got);
      if (want != got)
         log_mismatch($sformatf("word %0d %s: expected %0d, got %0d",
                                words_checked, name, want, got));
   endtask

   // One sample into the frame accumulator; returns 1 when the frame closes
   function automatic bit advance_gate(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t,
                                       output gate_word_type w);
      int          sv;
      logic [24:0] wide;
      logic [31:0] avg;
      logic        is_voice;
      sv   = s;
      wide = acc_level + 25'(sv < 0 ? -sv : sv);
      acc_level = wide[24] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
      acc_count++;
      w = '0;
      if (acc_count < FRAME_SAMPLES) return 1'b0;
      avg = 32'(acc_level) / FRAME_SAMPLES;
      acc_level = '0;
      acc_count = 0;
      is_voice = avg > 32'(cfg_model[REG_VOICE_THRESHOLD]);
      if (is_voice) begin
         voice_stamp = t;
         if (!last_was_voice) onset_stamp = t;
         if (!gate_is_open && (t - onset_stamp) >= 32'(cfg_model[REG_MIN_VOICE_MS])) begin
            gate_is_open = 1'b1;
            w.started = 1'b1;
         end
      end else if (gate_is_open &&
                   (t - voice_stamp) >= 32'(cfg_model[REG_SILENCE_TIMEOUT_MS])) begin
         gate_is_open = 1'b0;
         w.stopped = 1'b1;
      end
      last_was_voice = is_voice;
      w.sending   = gate_is_open;
      w.voice     = is_voice;
      w.avg_level = avg[LEVEL_W-1:0];
      return 1'b1;
   endfunction

   // Watch both channels at the rising edge: predict on accepted samples, check result words
   always @(posedge clock) begin : watch
      gate_word_type want;
      if (!reset && req_chan.valid && req_chan.ready) begin
         samples_sent++;
         if (advance_gate(req_chan.sample, req_chan.now_ms, want))
            pending_words.push_back(pin_active ? pin_word : want);
      end
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_words.size() == 0) begin
            log_mismatch($sformatf("unexpected word: sending %0d voice %0d level %0d",
                                   rsp_chan.sending, rsp_chan.voice, rsp_chan.avg_level));
         end else begin
            want = pending_words.pop_front();
            check_field("sending", want.sending, rsp_chan.sending);
            check_field("voice", want.voice, rsp_chan.voice);
            check_field("avg_level", want.avg_level, rsp_chan.avg_level);
            check_field("started", want.started, rsp_chan.started);
            check_field("stopped", want.stopped, rsp_chan.stopped);
            words_checked++;
            voice_seen  += want.voice;
            opens_seen  += want.started;
            closes_seen += want.stopped;
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycle_count, pending_words.size());
         $display("testbench: done, errors");
         $finish;
      end
   end

   // Result side: random stalls, plus a long hold-off on request
   initial begin : result_sink
      int hold_left;
      int holds_served;
      hold_left    = 0;
      holds_served = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_requests) begin
            holds_served = hold_requests;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= sink_stall_pct);
         end
      end
   end

   // Sample word out on the request channel; returns at the falling edge after acceptance
   task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic [TIME_W-1:0] t);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid  <= 1'b1;
      req_chan.sample <= s;
      req_chan.now_ms <= t;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   function automatic logic signed [SAMPLE_W-1:0] pattern_sample(pattern_type p, int mag,
                                                                 int spread, int i);
      int m;
      case (p)
         PAT_POS:   return SAMPLE_W'(mag);
         PAT_NEG:   return SAMPLE_W'(-mag);
         PAT_ALT:   return i[0] ? SAMPLE_W'(-mag) : SAMPLE_W'(mag);
         PAT_RAMP:  return SAMPLE_W'(i * 97 - 15000);
         PAT_NOISE: return SAMPLE_W'($urandom());
         default: begin
            // magnitude jittered around mag, random sign; full scale only as negative
            m = mag - spread + int'($urandom_range(2 * spread));
            if (m < 0) m = 0;
            if (m > 32768) m = 32768;
            if (m == 32768 || $urandom_range(1) == 1) return SAMPLE_W'(-m);
            return SAMPLE_W'(m);
         end
      endcase
   endfunction

   // A full frame; timestamp only matters on the last sample, the rest get random bits
   task automatic send_frame(pattern_type p, int mag, int spread, logic [TIME_W-1:0] stamp);
      for (int i = 0; i < FRAME_SAMPLES; i++)
         send_word(pattern_sample(p, mag, spread, i),
                   (i == FRAME_SAMPLES - 1) ? stamp : TIME_W'($urandom()));
   endtask

   // Stop offering and wait until every frame word is back and the back end is quiet
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic csr_access(logic wr, logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic check_regs();
      logic [CSR_DATA_W-1:0] rd;
      for (int i = REG_VOICE_THRESHOLD; i <= REG_SILENCE_TIMEOUT_MS; i++) begin
         csr_access(1'b0, REG_IDX_W'(i), '0, rd);
         if (rd[CFG_W-1:0] != cfg_model[i])
            log_mismatch($sformatf("register %0d reads %0d, expected %0d",
                                   i, rd[CFG_W-1:0], cfg_model[i]));
      end
   endtask

   // Upper data bits are junk; only the low 16 land in the register
   task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, idx, {16'($urandom()), value}, rd);
      if (idx <= REG_SILENCE_TIMEOUT_MS) cfg_model[idx] = value;
      check_regs();
   endtask

   // Random phase: voice and silence runs of a few frames, time jumps and noise frames
   task automatic run_phase(int idle_pct, int stall_pct, logic [CFG_W-1:0] thr,
                            logic [CFG_W-1:0] min_ms, logic [CFG_W-1:0] hang_ms,
                            int frames, bit squeeze);
      bit talking;
      int run_left;
      int roll;
      int level;
      talking  = 1'b0;
      run_left = 0;
      drain_results();
      write_reg(REG_UNMAPPED, 16'($urandom()));
      write_reg(REG_VOICE_THRESHOLD, thr);
      write_reg(REG_MIN_VOICE_MS, min_ms);
      write_reg(REG_SILENCE_TIMEOUT_MS, hang_ms);
      sender_idle_pct = idle_pct;
      sink_stall_pct  = stall_pct;
      if (squeeze) hold_requests++;
      for (int f = 0; f < frames; f++) begin
         if (run_left == 0) begin
            talking  = !talking;
            run_left = $urandom_range(1, 8);
         end
         run_left--;
         roll = $urandom_range(99);
         clock_ms += TIME_W'($urandom_range(15, 25));
         if (roll < 5) clock_ms += TIME_W'($urandom());
         else if (roll < 8) clock_ms -= TIME_W'($urandom_range(1, 100));
         level = talking ? int'(thr) + int'($urandom_range(600)) : int'($urandom_range(thr));
         if (level > 32768) level = 32768;
         send_frame(roll >= 92 ? PAT_NOISE : PAT_SPREAD, level,
                    int'($urandom_range(200)), clock_ms);
      end
   endtask

   function automatic gate_word_type word(bit sending, bit voice, int lvl, bit started,
                                          bit stopped);
      return '{sending, voice, LEVEL_W'(lvl), started, stopped};
   endfunction

   function automatic plan_row_type frame_row(pattern_type p, int mag,
                                              logic [TIME_W-1:0] stamp,
                                              bit pin, gate_word_type want);
      return '{ROW_FRAME, REG_VOICE_THRESHOLD, '0, p, 17'(mag), stamp, pin, want};
   endfunction

   function automatic plan_row_type write_row(logic [REG_IDX_W-1:0] idx, int value);
      return '{ROW_WRITE, idx, CFG_W'(value), PAT_POS, '0, '0, 1'b0, '0};
   endfunction

   initial begin : main
      plan_row_type plan [$];
      reset   = 1'b1;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;
      req_chan.valid  = 1'b0;
      req_chan.sample = '0;
      req_chan.now_ms = '0;
      cfg_model      = '{RST_VOICE_THRESHOLD, RST_MIN_VOICE_MS, RST_SILENCE_TIMEOUT_MS};
      acc_level      = '0;
      acc_count      = 0;
      gate_is_open   = 1'b0;
      last_was_voice = 1'b0;
      onset_stamp    = '0;
      voice_stamp    = '0;

      // Directed frames; pinned rows carry their result word, the rest go to the predictor
      plan.push_back(frame_row(PAT_POS, 0, 32'd0, 1'b1, word(0, 0, 0, 0, 0)));
      plan.push_back(frame_row(PAT_NEG, 32768, 32'd10, 1'b1, word(0, 1, 32768, 0, 0)));
      plan.push_back(frame_row(PAT_POS, 32767, 32'd100, 1'b1, word(0, 1, 32767, 0, 0)));
      // onset was at 10 ms, so 210 ms reaches the minimum duration exactly
      plan.push_back(frame_row(PAT_ALT, 1001, 32'd210, 1'b1, word(1, 1, 1001, 1, 0)));
      // level equal to threshold is not voice
      plan.push_back(frame_row(PAT_ALT, 1000, 32'd220, 1'b1, word(1, 0, 1000, 0, 0)));
      plan.push_back(frame_row(PAT_RAMP, 0, 32'd300, 1'b0, '0));
      // hangover: one ms short of the timeout, then exactly on it
      plan.push_back(frame_row(PAT_POS, 0, 32'd1799, 1'b1, word(1, 0, 0, 0, 0)));
      plan.push_back(frame_row(PAT_POS, 0, 32'd1800, 1'b1, word(0, 0, 0, 0, 1)));
      plan.push_back(frame_row(PAT_NOISE, 0, 32'd5000, 1'b0, '0));
      plan.push_back(write_row(REG_UNMAPPED, 16'h1234));
      plan.push_back(write_row(REG_VOICE_THRESHOLD, 5000));
      plan.push_back(frame_row(PAT_POS, 5000, 32'hFFFF_FFF0, 1'b1, word(0, 0, 5000, 0, 0)));
      plan.push_back(frame_row(PAT_NEG, 5001, 32'hFFFF_FFF0, 1'b1, word(0, 1, 5001, 0, 0)));
      // time wraps past zero: 208 ms since onset
      plan.push_back(frame_row(PAT_POS, 6000, 32'h0000_00C0, 1'b1, word(1, 1, 6000, 1, 0)));
      // clock runs backwards: looks like a very long silence
      plan.push_back(frame_row(PAT_POS, 0, 32'h0000_0010, 1'b1, word(0, 0, 0, 0, 1)));
      plan.push_back(write_row(REG_VOICE_THRESHOLD, 0));
      plan.push_back(write_row(REG_MIN_VOICE_MS, 0));
      plan.push_back(write_row(REG_SILENCE_TIMEOUT_MS, 0));
      // zero minimum opens on the first voice frame, zero timeout closes at once
      plan.push_back(frame_row(PAT_POS, 1, 32'd77, 1'b1, word(1, 1, 1, 1, 0)));
      plan.push_back(frame_row(PAT_POS, 0, 32'd77, 1'b1, word(0, 0, 0, 0, 1)));
      plan.push_back(write_row(REG_VOICE_THRESHOLD, 32768));
      plan.push_back(write_row(REG_MIN_VOICE_MS, 65535));
      plan.push_back(write_row(REG_SILENCE_TIMEOUT_MS, 65535));
      plan.push_back(frame_row(PAT_NEG, 32768, 32'd9, 1'b1, word(0, 0, 32768, 0, 0)));
      plan.push_back(frame_row(PAT_NOISE, 0, 32'hFFFF_FFFF, 1'b0, '0));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset values of the registers
      check_regs();

      foreach (plan[r]) begin
         if (plan[r].kind == ROW_WRITE) begin
            drain_results();
            write_reg(plan[r].csr_idx, plan[r].wdata);
         end else begin
            pin_active = plan[r].pinned;
            pin_word   = plan[r].want;
            send_frame(plan[r].pattern, plan[r].mag, 0, plan[r].stamp);
            pin_active = 1'b0;
         end
      end

      // Random phases: no idling, sender idle, receiver stalling, both, then a long hold-off
      run_phase(0, 0, 16'd800, 16'd40, 16'd60, 12, 1'b0);
      run_phase(83, 0, 16'd0, 16'd0, 16'd0, 12, 1'b0);
      run_phase(0, 83, 16'd3000, 16'hFFFF, 16'hFFFF, 12, 1'b0);
      run_phase(14, 14, 16'($urandom_range(4000)), 16'($urandom_range(120)),
                16'($urandom_range(200)), 12, 1'b0);
      run_phase(0, 0, 16'($urandom_range(4000)), 16'($urandom_range(120)),
                16'($urandom_range(200)), 14, 1'b1);
      drain_results();

      $display("testbench: %0d samples in, %0d frame words checked, %0d of them voice",
               samples_sent, words_checked, voice_seen);
      $display("testbench: gate opened %0d times, closed on timeout %0d times",
               opens_seen, closes_seen);
      if (mismatches == 0 && pending_words.size() == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: %0d mismatches", mismatches);
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/evag_pkg.sv
hw/rtl/evag_req_if.sv
hw/rtl/evag_rsp_if.sv
hw/rtl/evag_front.sv
hw/rtl/evag_queue.sv
hw/rtl/evag_back.sv
hw/rtl/energy_voice_activity_gate.sv
hw/rtl/evag_checker.sv
tb/testbench.sv
